// ----- rtl/core/fta_pkg.sv -----
package fta_pkg;

	localparam int TS_W     = 64;
	localparam int ACC_W    = 40;
	localparam int STEP_W   = 32;
	localparam int SCALE_W  = 24;
	localparam int BUDGET_W = 8;
	localparam int CNT32_W  = 32;
	localparam int FRAC_W   = 16;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// digit width of the serial scale multiplier; must divide TS_W
	localparam int DIGIT_W_DEF = 8;

	localparam logic [CFG_IDX_W-1:0] REG_FIXED_STEP = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SCALE      = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_PAUSED     = CFG_IDX_W'(3);

	localparam logic [STEP_W-1:0]   FIXED_STEP_RST = STEP_W'(16666667);
	localparam logic [SCALE_W-1:0]  SCALE_RST      = SCALE_W'(65536);
	localparam logic [BUDGET_W-1:0] MAX_STEPS_RST  = BUDGET_W'(5);

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_CONSUME = 2'd1,
		REQ_SINGLE  = 2'd2,
		REQ_RESTART = 2'd3
	} req_kind_t;

	typedef struct packed {
		req_kind_t             req_type;
		logic [TS_W-1:0]       timestamp_ns;
		logic                  override_valid;
		logic [STEP_W-1:0]     override_dt_ns;
		logic [BUDGET_W-1:0]   step_count;
	} req_t;

	typedef struct packed {
		logic [BUDGET_W-1:0] avail_steps;
		logic [ACC_W-1:0]    accumulated_ns;
		logic [ACC_W-1:0]    scaled_delta_ns;
		logic [CNT32_W-1:0]  frame_count;
		logic [CNT32_W-1:0]  steps_done;
		logic [TS_W-1:0]     sim_time_ns;
	} rsp_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] scaled;
	} mul_res_t;

	typedef struct packed {
		logic                done;
		logic [BUDGET_W-1:0] budget;
	} div_res_t;

endpackage

// ----- rtl/core/fta_mul.sv -----
module fta_mul import fta_pkg::*; #(
	parameter int DIGIT_W = DIGIT_W_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [TS_W-1:0]    dt,
	input  logic [SCALE_W-1:0] scale,
	output mul_res_t           res
);

	localparam int NDIG  = TS_W / DIGIT_W;
	localparam int CNT_W = $clog2(NDIG);
	localparam int SUM_W = SCALE_W + DIGIT_W;

	logic [TS_W-1:0]    dt_q;
	logic [TS_W-1:0]    low_q;
	logic [SCALE_W-1:0] hi_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [SUM_W-1:0]   sum;

	// hi_q plus one digit times scale always fits SUM_W bits
	assign sum = SUM_W'(hi_q) + SUM_W'(dt_q[DIGIT_W-1:0]) * SUM_W'(scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NDIG - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dt_q <= dt;
			hi_q <= '0;
		end else if (busy_q) begin
			dt_q  <= dt_q >> DIGIT_W;
			low_q <= {sum[DIGIT_W-1:0], low_q[TS_W-1:DIGIT_W]};
			hi_q  <= sum[SUM_W-1:DIGIT_W];
		end
	end

	// product is {hi_q, low_q}; keep bits above the Q16 fraction, saturate at 40 bits
	always_comb begin
		res.done = done_q;
		if (hi_q != '0 || low_q[TS_W-1:ACC_W+FRAC_W] != '0)
			res.scaled = '1;
		else
			res.scaled = low_q[ACC_W+FRAC_W-1:FRAC_W];
	end

endmodule

// ----- rtl/core/fta_div.sv -----
module fta_div import fta_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [ACC_W-1:0]    acc,
	input  logic [STEP_W-1:0]   fs,
	input  logic [BUDGET_W-1:0] cap,
	output div_res_t            res
);

	localparam int CNT_W = $clog2(BUDGET_W);

	logic [ACC_W-1:0]    rem_q;
	logic [ACC_W-1:0]    dv_q;
	logic [BUDGET_W-1:0] quo_q;
	logic [BUDGET_W-1:0] budget_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic                zero_q;
	logic                sat_q;
	logic                ge;
	logic [BUDGET_W-1:0] quo_next;

	assign ge       = rem_q >= dv_q;
	assign quo_next = {quo_q[BUDGET_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(BUDGET_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= acc;
			dv_q   <= ACC_W'(fs) << (BUDGET_W - 1);
			quo_q  <= '0;
			zero_q <= fs == '0;
			// a quotient of 256 or more always exceeds the cap
			sat_q  <= acc >= (ACC_W'(fs) << BUDGET_W);
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dv_q;
			dv_q  <= dv_q >> 1;
			quo_q <= quo_next;
			if (cnt_q == '0) begin
				if (zero_q)
					budget_q <= '0;
				else if (sat_q || quo_next > cap)
					budget_q <= cap;
				else
					budget_q <= quo_next;
			end
		end
	end

	assign res.done   = done_q;
	assign res.budget = budget_q;

endmodule

// ----- rtl/core/fixed_timestep_accumulator.sv -----
// Fixed-timestep credit accumulator. Each request on the req channel (tick, consume,
// single step, restart) yields exactly one result on the rsp channel with the step
// budget and the counters after the request. One request is worked on at a time:
// a running tick passes through the digit-serial scale multiplier, which takes one
// DIGIT_W-bit digit of the frame delta per cycle, and then through the budget
// divider, which resolves one quotient bit per cycle over 8 bits; a consume, a
// paused tick, a single-step request or a restart goes through the divider only.
// A finished result waits in the output register while the next request is taken;
// the block holds in its last state while that register is still stalled.
// Configuration writes are taken in any cycle and belong in idle periods only.
module fixed_timestep_accumulator import fta_pkg::*; #(
	parameter int DIGIT_W = DIGIT_W_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_FRONT  = 7'b0000010,
		S_MUL    = 7'b0000100,
		S_UPD    = 7'b0001000,
		S_DSTART = 7'b0010000,
		S_DIV    = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	state_t state_q;

	logic [STEP_W-1:0]   fixed_step_q;
	logic [SCALE_W-1:0]  scale_q;
	logic [BUDGET_W-1:0] max_steps_q;
	logic                paused_q;

	logic [TS_W-1:0]    last_stamp_q;
	logic [CNT32_W-1:0] frame_q;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   scaled_q;
	logic [CNT32_W-1:0] step_total_q;
	logic [TS_W-1:0]    sim_time_q;
	logic               pending_q;

	req_t             req_q;
	logic [ACC_W-1:0] addend_q;
	logic [ACC_W-1:0] prod_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic [BUDGET_W-1:0] cap;
	logic [TS_W-1:0]     dt;
	logic                mul_start;
	logic                div_start;
	logic                rsp_load;
	logic                do_consume;
	logic [ACC_W:0]      tick_sum;
	mul_res_t            mul_res;
	div_res_t            div_res;

	assign cap        = (max_steps_q == '0) ? BUDGET_W'(1) : max_steps_q;
	assign req_stall  = state_q != S_IDLE;
	assign cfg_ready  = 1'b1;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign mul_start  = state_q == S_FRONT && req_q.req_type == REQ_TICK && !paused_q;
	assign div_start  = state_q == S_DSTART;
	assign rsp_load   = state_q == S_OUT && (!rsp_valid_q || !rsp_stall);
	assign do_consume = req_q.step_count != '0 && fixed_step_q != '0;
	assign tick_sum   = {1'b0, acc_q} + {1'b0, addend_q};

	always_comb begin
		if (req_q.override_valid)
			dt = TS_W'(req_q.override_dt_ns);
		else if (last_stamp_q == '0)
			dt = '0;
		else
			dt = req_q.timestamp_ns - last_stamp_q;
	end

	fta_mul #(
		.DIGIT_W(DIGIT_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.dt     (dt),
		.scale  (scale_q),
		.res    (mul_res)
	);

	fta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.acc    (acc_q),
		.fs     (fixed_step_q),
		.cap    (cap),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_step_q <= FIXED_STEP_RST;
			scale_q      <= SCALE_RST;
			max_steps_q  <= MAX_STEPS_RST;
			paused_q     <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FIXED_STEP: fixed_step_q <= cfg_data[STEP_W-1:0];
				REG_SCALE:      scale_q      <= cfg_data[SCALE_W-1:0];
				REG_MAX_STEPS:  max_steps_q  <= cfg_data[BUDGET_W-1:0];
				REG_PAUSED:     paused_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_stamp_q <= '0;
			frame_q      <= '0;
			acc_q        <= '0;
			scaled_q     <= '0;
			step_total_q <= '0;
			sim_time_q   <= '0;
			pending_q    <= 1'b0;
			addend_q     <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (req_valid)
						state_q <= S_FRONT;
				end
				S_FRONT: begin
					case (req_q.req_type)
						REQ_TICK: begin
							last_stamp_q <= req_q.timestamp_ns;
							if (last_stamp_q == '0)
								frame_q <= '0;
							else
								frame_q <= frame_q + CNT32_W'(1);
							if (paused_q) begin
								scaled_q <= '0;
								addend_q <= pending_q ? ACC_W'(fixed_step_q) : '0;
								state_q  <= S_UPD;
							end else begin
								state_q <= S_MUL;
							end
						end
						REQ_CONSUME: begin
							pending_q <= 1'b0;
							state_q   <= S_UPD;
						end
						REQ_SINGLE: begin
							pending_q <= 1'b1;
							state_q   <= S_DSTART;
						end
						REQ_RESTART: begin
							frame_q      <= '0;
							last_stamp_q <= req_q.timestamp_ns;
							acc_q        <= '0;
							sim_time_q   <= '0;
							scaled_q     <= '0;
							step_total_q <= '0;
							pending_q    <= 1'b0;
							state_q      <= S_DSTART;
						end
						default: state_q <= S_DSTART;
					endcase
				end
				S_MUL: begin
					if (mul_res.done) begin
						scaled_q <= mul_res.scaled;
						addend_q <= mul_res.scaled;
						state_q  <= S_UPD;
					end
				end
				S_UPD: begin
					if (req_q.req_type == REQ_TICK) begin
						// clamp to fixed step times the cap
						if (tick_sum > {1'b0, prod_q})
							acc_q <= prod_q;
						else
							acc_q <= tick_sum[ACC_W-1:0];
					end else if (do_consume) begin
						acc_q        <= (acc_q > prod_q) ? acc_q - prod_q : '0;
						sim_time_q   <= sim_time_q + TS_W'(prod_q);
						step_total_q <= step_total_q + CNT32_W'(req_q.step_count);
					end
					state_q <= S_DSTART;
				end
				S_DSTART: state_q <= S_DIV;
				S_DIV: begin
					if (div_res.done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid)
			req_q <= req;
		// clamp limit for a tick, spent credit for a consume
		if (state_q == S_FRONT) begin
			if (req_q.req_type == REQ_TICK)
				prod_q <= ACC_W'(fixed_step_q) * ACC_W'(cap);
			else
				prod_q <= ACC_W'(fixed_step_q) * ACC_W'(req_q.step_count);
		end
		if (rsp_load) begin
			rsp_q.avail_steps     <= div_res.budget;
			rsp_q.accumulated_ns  <= acc_q;
			rsp_q.scaled_delta_ns <= scaled_q;
			rsp_q.frame_count     <= frame_q;
			rsp_q.steps_done      <= step_total_q;
			rsp_q.sim_time_ns     <= sim_time_q;
		end
	end

endmodule

// ----- rtl/core/fta_chk.sv -----
module fta_chk import fta_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed or dropped");

	// stall the request side while a transfer is being worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one still in flight");

	// an empty accumulator can fund no step
	a_empty_budget: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.accumulated_ns == '0 |-> rsp.avail_steps == '0)
		else $error("nonzero budget with empty accumulator");

endmodule

bind fixed_timestep_accumulator fta_chk u_fta_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import fta_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int NUM_PHASES  = 7;
	localparam int PHASE_ITEMS = 215;
	localparam int PRINT_LIMIT = 100;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_TOP    = '1;

	class credit_scoreboard;
		logic [STEP_W-1:0]   fixed_step;
		logic [SCALE_W-1:0]  scale;
		logic [BUDGET_W-1:0] max_steps;
		logic                paused;

		logic [TS_W-1:0]    last_stamp;
		logic [CNT32_W-1:0] frames;
		logic [ACC_W-1:0]   credit;
		logic [ACC_W-1:0]   last_scaled;
		logic [CNT32_W-1:0] steps;
		logic [TS_W-1:0]    sim_ns;
		logic               single_pend;

		rsp_t rsp_due[$];
		int   errors;
		int   results;

		function new();
			fixed_step = FIXED_STEP_RST;
			scale      = SCALE_RST;
			max_steps  = MAX_STEPS_RST;
			paused     = 1'b0;
			restart_state('0);
			errors  = 0;
			results = 0;
		endfunction

		function void restart_state(logic [TS_W-1:0] stamp);
			last_stamp  = stamp;
			frames      = '0;
			credit      = '0;
			last_scaled = '0;
			steps       = '0;
			sim_ns      = '0;
			single_pend = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_FIXED_STEP: fixed_step = data[STEP_W-1:0];
			REG_SCALE:      scale      = data[SCALE_W-1:0];
			REG_MAX_STEPS:  max_steps  = data[BUDGET_W-1:0];
			REG_PAUSED:     paused     = data[0];
			default: ;
			endcase
		endfunction

		function logic [63:0] step_cap();
			return (max_steps == '0) ? 64'd1 : 64'(max_steps);
		endfunction

		// floor(dt * scale / 2^16), saturated to the accumulator width
		function logic [ACC_W-1:0] scale_delta(logic [TS_W-1:0] dt);
			logic [TS_W+SCALE_W-1:0] prod;
			prod = {{SCALE_W{1'b0}}, dt} * {{TS_W{1'b0}}, scale};
			if (prod[TS_W+SCALE_W-1:FRAC_W+ACC_W] != '0)
				return '1;
			return prod[FRAC_W+ACC_W-1:FRAC_W];
		endfunction

		function logic [BUDGET_W-1:0] budget();
			logic [63:0] quo;
			if (fixed_step == '0)
				return '0;
			quo = 64'(credit) / 64'(fixed_step);
			return BUDGET_W'((quo < step_cap()) ? quo : step_cap());
		endfunction

		function void note_request(req_t r);
			logic [TS_W-1:0] dt;
			logic [63:0]     sum;
			logic [63:0]     limit;
			logic [63:0]     used;
			rsp_t            exp_rsp;
			case (r.req_type)
			REQ_TICK: begin
				dt = '0;
				if (last_stamp == '0) begin
					frames     = '0;
					last_stamp = r.timestamp_ns;
				end else begin
					dt         = r.timestamp_ns - last_stamp;
					last_stamp = r.timestamp_ns;
					frames     = frames + CNT32_W'(1);
				end
				if (r.override_valid)
					dt = TS_W'(r.override_dt_ns);
				sum = 64'(credit);
				if (paused) begin
					last_scaled = '0;
					if (single_pend)
						sum = sum + 64'(fixed_step);
				end else begin
					last_scaled = scale_delta(dt);
					sum = sum + 64'(last_scaled);
				end
				limit  = 64'(fixed_step) * step_cap();
				credit = ACC_W'((sum > limit) ? limit : sum);
			end
			REQ_CONSUME: begin
				if (r.step_count != '0 && fixed_step != '0) begin
					used   = 64'(fixed_step) * 64'(r.step_count);
					credit = (64'(credit) > used) ? ACC_W'(64'(credit) - used) : '0;
					sim_ns = sim_ns + used;
					steps  = steps + CNT32_W'(r.step_count);
				end
				single_pend = 1'b0;
			end
			REQ_SINGLE: begin
				single_pend = 1'b1;
			end
			default: begin
				restart_state(r.timestamp_ns);
			end
			endcase
			exp_rsp.avail_steps     = budget();
			exp_rsp.accumulated_ns  = credit;
			exp_rsp.scaled_delta_ns = last_scaled;
			exp_rsp.frame_count     = frames;
			exp_rsp.steps_done      = steps;
			exp_rsp.sim_time_ns     = sim_ns;
			rsp_due.push_back(exp_rsp);
		endfunction

		task report(string msg);
			if (errors < PRINT_LIMIT)
				$display("ERROR: %0t result %0d: %s", $realtime, results, msg);
			errors++;
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			results++;
			if (rsp_due.size() == 0) begin
				report("transfer with no result outstanding");
				return;
			end
			want = rsp_due.pop_front();
			if (got.avail_steps !== want.avail_steps)
				report($sformatf("avail_steps %0d, want %0d", got.avail_steps,
					want.avail_steps));
			if (got.accumulated_ns !== want.accumulated_ns)
				report($sformatf("accumulated_ns %0h, want %0h", got.accumulated_ns,
					want.accumulated_ns));
			if (got.scaled_delta_ns !== want.scaled_delta_ns)
				report($sformatf("scaled_delta_ns %0h, want %0h", got.scaled_delta_ns,
					want.scaled_delta_ns));
			if (got.frame_count !== want.frame_count)
				report($sformatf("frame_count %0h, want %0h", got.frame_count,
					want.frame_count));
			if (got.steps_done !== want.steps_done)
				report($sformatf("steps_done %0h, want %0h", got.steps_done,
					want.steps_done));
			if (got.sim_time_ns !== want.sim_time_ns)
				report($sformatf("sim_time_ns %0h, want %0h", got.sim_time_ns,
					want.sim_time_ns));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int          snd_idle = 0;
	int          rcv_idle = 0;
	int          rcv_hold = 0;
	logic [63:0] wall_ns;
	credit_scoreboard sb;

	fixed_timestep_accumulator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: a pending hold-off wins over random stalls
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
				sb.check_result(rsp);
			if (rcv_hold > 0) begin
				rsp_stall <= 1'b1;
				rcv_hold--;
			end else begin
				rsp_stall <= ($urandom_range(99) < rcv_idle);
			end
		end
	end

	function req_t make_req(req_kind_t kind, logic [TS_W-1:0] ts, logic ovr,
			logic [STEP_W-1:0] ovr_dt, logic [BUDGET_W-1:0] cnt);
		req_t r;
		r.req_type       = kind;
		r.timestamp_ns   = ts;
		r.override_valid = ovr;
		r.override_dt_ns = ovr_dt;
		r.step_count     = cnt;
		return r;
	endfunction

	task send(input req_t r);
		while ($urandom_range(99) < snd_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall !== 1'b0);
		sb.note_request(r);
	endtask

	// hold the input until every outstanding result is back, then let the block settle
	task drain();
		req_valid <= 1'b0;
		while (sb.rsp_due.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(idx, data);
	endtask

	task set_regs(input logic [STEP_W-1:0] fs, input logic [SCALE_W-1:0] sc,
			input logic [BUDGET_W-1:0] ms, input logic pz);
		cfg_write(REG_FIXED_STEP, fs);
		cfg_write(REG_SCALE, {8'($urandom), sc});
		cfg_write(REG_MAX_STEPS, {24'($urandom), ms});
		cfg_write(REG_PAUSED, {31'($urandom), pz});
		// out-of-range index must leave every register alone
		cfg_write($urandom_range(1) ? REG_UNUSED : REG_TOP, $urandom);
		cfg_valid <= 1'b0;
	endtask

	function req_t next_request();
		req_t r;
		int   pick;
		int   sel;
		logic [BUDGET_W-1:0] avail;
		r    = make_req(REQ_TICK, {$urandom, $urandom}, 1'($urandom), $urandom,
			8'($urandom));
		pick = $urandom_range(99);
		sel  = $urandom_range(99);
		if (pick < 7) begin
			r.req_type = req_kind_t'($urandom_range(3));
			if (r.req_type == REQ_TICK || r.req_type == REQ_RESTART)
				wall_ns = r.timestamp_ns;
		end else if (pick < 60) begin
			if (sel < 70)
				wall_ns = wall_ns + 64'($urandom_range(40000000, 8000000));
			else if (sel < 85)
				wall_ns = wall_ns + 64'($urandom_range(100000));
			else if (sel < 95)
				wall_ns = wall_ns + (64'($urandom) << $urandom_range(32));
			else
				wall_ns = wall_ns - 64'($urandom_range(1000000, 1));
			r.timestamp_ns   = wall_ns;
			r.override_valid = ($urandom_range(99) < 12);
		end else if (pick < 88) begin
			r.req_type = REQ_CONSUME;
			avail      = sb.budget();
			if (sel < 60)
				r.step_count = avail;
			else if (sel < 75)
				r.step_count = avail + BUDGET_W'($urandom_range(3, 1));
			else if (sel < 85)
				r.step_count = '0;
		end else if (pick < 95) begin
			r.req_type = REQ_SINGLE;
		end else begin
			r.req_type = REQ_RESTART;
			if (sel < 20)
				r.timestamp_ns = '0;
			else if (sel < 60)
				r.timestamp_ns = wall_ns;
			wall_ns = r.timestamp_ns;
		end
		return r;
	endfunction

	initial begin
		req_t r;
		int   mode;
		sb        = new();
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		wall_ns   = 64'd1000;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// frame clock start, wrap, saturation, empty and overdrawn consumes
		send(make_req(REQ_TICK, '0, 1'b0, '0, '0));
		send(make_req(REQ_TICK, 64'd1000, 1'b0, '1, '1));
		send(make_req(REQ_TICK, 64'd16667667, 1'b0, '0, '0));
		send(make_req(REQ_TICK, 64'd20000000, 1'b1, '1, '0));
		send(make_req(REQ_CONSUME, '1, 1'b1, '1, '0));
		send(make_req(REQ_CONSUME, '0, 1'b0, '0, 8'd3));
		send(make_req(REQ_CONSUME, '0, 1'b0, '0, '1));
		send(make_req(REQ_SINGLE, '1, 1'b1, '1, '1));
		send(make_req(REQ_TICK, 64'd5, 1'b0, '0, '0));
		send(make_req(REQ_RESTART, '1, 1'b0, '0, '0));
		send(make_req(REQ_TICK, 64'h10, 1'b0, '0, '0));
		send(make_req(REQ_TICK, 64'h20, 1'b1, '0, '0));
		send(make_req(REQ_CONSUME, '0, 1'b0, '0, 8'd1));
		drain();

		// paused: credit only from a pending single step, which lasts until a consume
		set_regs(FIXED_STEP_RST, '0, '0, 1'b1);
		send(make_req(REQ_TICK, 64'h30, 1'b0, '0, '0));
		send(make_req(REQ_SINGLE, '0, 1'b0, '0, '0));
		send(make_req(REQ_TICK, 64'h40, 1'b0, '0, '0));
		send(make_req(REQ_TICK, 64'h50, 1'b0, '0, '0));
		send(make_req(REQ_CONSUME, '0, 1'b0, '0, '0));
		send(make_req(REQ_TICK, 64'h60, 1'b0, '0, '0));
		drain();

		// zero step length disables stepping
		set_regs('0, '1, '1, 1'b0);
		send(make_req(REQ_TICK, 64'h70, 1'b1, '1, '0));
		send(make_req(REQ_CONSUME, '0, 1'b0, '0, 8'd5));
		send(make_req(REQ_RESTART, '0, 1'b0, '0, '0));
		send(make_req(REQ_TICK, 64'h1234, 1'b0, '0, '0));

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			case (ph)
			0: set_regs(FIXED_STEP_RST, SCALE_RST, MAX_STEPS_RST, 1'b0);
			1: set_regs('1, '1, '1, 1'b0);
			2: set_regs($urandom_range(5000000, 1000), 24'($urandom_range(255)), '0,
				1'b0);
			3: set_regs($urandom_range(40000000, 1), 24'($urandom_range(16777215)),
				8'($urandom_range(255)), 1'b1);
			4: set_regs('0, 24'($urandom_range(16777215)), 8'($urandom_range(255)),
				1'($urandom));
			5: set_regs($urandom, 24'($urandom_range(16777215)),
				8'($urandom_range(255)), 1'b0);
			default: set_regs($urandom_range(100000, 1), 24'($urandom_range(16777215)),
				'1, 1'($urandom));
			endcase
			mode = ph * 3 / NUM_PHASES;
			snd_idle = (mode == 0) ? 20 : (mode == 1) ? 65 : 0;
			rcv_idle = (mode == 0) ? 65 : (mode == 1) ? 20 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// long receiver hold-off so the block backs up into its input
				if (ph == 1 && i == 40)
					rcv_hold = 400;
				r = next_request();
				send(r);
			end
		end
		drain();
		repeat (20) @(posedge clk);

		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
